[rtl/core/bnmf_pkg.sv]
// ----------------------------------------------------------------------------
// bnmf_pkg
// Shared constants, types and helpers of the background normalization block.
// ----------------------------------------------------------------------------
package bnmf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_KERNEL = 8;
    localparam int RING       = 4 * MAX_KERNEL + 1;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int RING_W     = $clog2(RING);
    localparam int ADDR_W     = RING_W + COL_W;
    localparam int MEM_DEPTH  = RING * MAX_WIDTH;
    localparam int RAD_W      = $clog2(2 * MAX_KERNEL + 1);
    localparam int DIST_W     = $clog2(4 * MAX_KERNEL + 1);
    localparam int XW         = 11;
    localparam int YW         = 17;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_KERNEL = 2'd2;

    typedef struct packed {
        logic [XW-1:0]    width;
        logic [15:0]      height;
        logic [RAD_W-1:0] radius;
    } cfg_t;

    typedef struct packed {
        logic [7:0]        pix;
        logic [RING_W-1:0] xr;
        logic [RING_W-1:0] yr;
        logic [RING_W-1:0] ro;
        logic [COL_W-1:0]  xcol;
        logic [COL_W-1:0]  ccol;
        logic              wr_orig;
        logic              do_h;
        logic              do_out;
        logic              row_end;
        logic              frame_end;
        logic [DIST_W-1:0] dh_lo;
        logic [DIST_W-1:0] dh_hi;
        logic [DIST_W-1:0] dv_lo;
        logic [DIST_W-1:0] dv_hi;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE, BK_WRITE, BK_HREAD, BK_HLAST, BK_VREAD, BK_VLAST, BK_DIV, BK_OUT
    } back_state_t;

    function automatic logic [RING_W-1:0] ring_sub(input logic [RING_W-1:0] a,
                                                   input logic [RING_W-1:0] d);
        logic [RING_W:0] t;
        t = {1'b0, a} + (RING_W+1)'(RING) - {1'b0, d};
        if (a >= d) begin
            return a - d;
        end
        return t[RING_W-1:0];
    endfunction

    function automatic logic [RING_W-1:0] ring_inc(input logic [RING_W-1:0] a);
        if (a == RING_W'(RING - 1)) begin
            return '0;
        end
        return a + 1'b1;
    endfunction

endpackage

[rtl/core/bnmf_front.sv]
// ----------------------------------------------------------------------------
// bnmf_front
// Tracks the frame position of each accepted beat and classifies it.
// ----------------------------------------------------------------------------
module bnmf_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  bnmf_pkg::cfg_t cfg,
    input  logic          push,
    input  logic [7:0]    pixel,
    input  logic          frame_first,
    output bnmf_pkg::cmd_t cmd
);
    import bnmf_pkg::*;

    logic [XW-1:0]     col_reg, col_next;
    logic [YW-1:0]     row_reg, row_next;
    logic [RING_W-1:0] xr_reg, xr_next, yr_reg, yr_next;

    logic [XW-1:0]     x;
    logic [YW-1:0]     y;
    logic [RING_W-1:0] xr, yr;
    logic [YW:0]       xe, ye, re, we, he, twor;

    always_comb begin
        x  = frame_first ? '0 : col_reg;
        y  = frame_first ? '0 : row_reg;
        xr = frame_first ? '0 : xr_reg;
        yr = frame_first ? '0 : yr_reg;
        xe = (YW+1)'(x);
        ye = (YW+1)'(y);
        re = (YW+1)'(cfg.radius);
        we = (YW+1)'(cfg.width);
        he = (YW+1)'(cfg.height);
        twor = re + re;

        cmd.pix     = pixel;
        cmd.xr      = xr;
        cmd.yr      = yr;
        cmd.ro      = ring_sub(yr, RING_W'(cfg.radius));
        cmd.xcol    = x[COL_W-1:0];
        cmd.ccol    = COL_W'(xe - re);
        cmd.wr_orig = (ye < he) && (xe < we);
        cmd.do_h    = (ye < he) && (xe >= re) && (xe - re < we);
        cmd.do_out  = (ye >= re) && (xe >= re) && (ye - re < he) && (xe - re < we);
        cmd.row_end   = (xe - re == we - 1'b1);
        cmd.frame_end = (xe - re == we - 1'b1) && (ye - re == he - 1'b1);
        cmd.dh_lo = (xe > we - 1'b1) ? DIST_W'(xe - we + 1'b1) : '0;
        cmd.dh_hi = (xe >= twor) ? DIST_W'(twor) : DIST_W'(xe);
        cmd.dv_lo = (ye > he - 1'b1) ? DIST_W'(ye - he + 1'b1) : '0;
        cmd.dv_hi = (ye >= twor) ? DIST_W'(twor) : DIST_W'(ye);

        col_next = col_reg;
        row_next = row_reg;
        xr_next  = xr_reg;
        yr_next  = yr_reg;
        if (push) begin
            if (xe + 1'b1 >= we + re) begin
                col_next = '0;
                xr_next  = '0;
                if (ye + 1'b1 >= he + re) begin
                    row_next = '0;
                    yr_next  = '0;
                end else begin
                    row_next = y + 1'b1;
                    yr_next  = ring_inc(yr);
                end
            end else begin
                col_next = x + 1'b1;
                xr_next  = ring_inc(xr);
                row_next = y;
                yr_next  = yr;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            xr_reg  <= '0;
            yr_reg  <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            xr_reg  <= xr_next;
            yr_reg  <= yr_next;
        end
    end

endmodule

[rtl/core/bnmf_queue.sv]
// ----------------------------------------------------------------------------
// bnmf_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module bnmf_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  bnmf_pkg::cmd_t push_data,
    input  logic           pop,
    output bnmf_pkg::cmd_t pop_data,
    output logic           full,
    output logic           empty
);
    import bnmf_pkg::*;

    cmd_t              store_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [Q_PTR_W:0]   cnt_reg, cnt_next;

    always_comb begin
        full     = (cnt_reg == (Q_PTR_W+1)'(Q_DEPTH));
        empty    = (cnt_reg == '0);
        pop_data = store_reg[rp_reg];
        wp_next  = push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

[rtl/core/bnmf_back.sv]
// ----------------------------------------------------------------------------
// bnmf_back
// Executes queued commands: line stores, window maxima, division, output beat.
// ----------------------------------------------------------------------------
module bnmf_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_empty,
    input  bnmf_pkg::cmd_t q_data,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic           m_tuser,
    output logic           m_tlast
);
    import bnmf_pkg::*;

    logic [7:0] rw_mem   [RING];
    logic [7:0] orig_mem [MEM_DEPTH];
    logic [7:0] hmax_mem [MEM_DEPTH];

    back_state_t       state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [DIST_W-1:0] d_reg, d_next;
    logic [7:0]        acc_reg, acc_next;
    logic              rdv_reg, rdv_next;
    logic [7:0]        rem_reg, rem_next, bg_reg, bg_next;
    logic [15:0]       quo_reg, quo_next;
    logic [3:0]        step_reg, step_next;
    logic              mv_reg, mv_next;
    logic [7:0]        md_reg, md_next;
    logic              mu_reg, mu_next, ml_reg, ml_next;

    logic              rw_we, org_we, hm_we;
    logic [RING_W-1:0] rw_raddr;
    logic [ADDR_W-1:0] org_waddr, org_raddr, hm_waddr, hm_raddr;
    logic [7:0]        hm_wdata, rw_q, org_q, hm_q, mx;
    logic [8:0]        rem_sh;

    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        d_next     = d_reg;
        acc_next   = acc_reg;
        rdv_next   = 1'b0;
        rem_next   = rem_reg;
        bg_next    = bg_reg;
        quo_next   = quo_reg;
        step_next  = step_reg;
        mv_next    = mv_reg && !m_tready;
        md_next    = md_reg;
        mu_next    = mu_reg;
        ml_next    = ml_reg;
        q_pop      = 1'b0;
        rw_we      = 1'b0;
        org_we     = 1'b0;
        hm_we      = 1'b0;
        rw_raddr   = ring_sub(cmd_reg.xr, RING_W'(d_reg));
        org_waddr  = {cmd_reg.yr, cmd_reg.xcol};
        org_raddr  = {cmd_reg.ro, cmd_reg.ccol};
        hm_waddr   = {cmd_reg.yr, cmd_reg.ccol};
        hm_raddr   = {ring_sub(cmd_reg.yr, RING_W'(d_reg)), cmd_reg.ccol};
        mx         = (rw_q > acc_reg) ? rw_q : acc_reg;
        hm_wdata   = mx;
        rem_sh     = {rem_reg, quo_reg[15]};

        if (rdv_reg) begin
            acc_next = (state_reg == BK_HLAST || state_reg == BK_HREAD) ? mx :
                       ((hm_q > acc_reg) ? hm_q : acc_reg);
        end

        unique case (state_reg)
            BK_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    cmd_next   = q_data;
                    state_next = BK_WRITE;
                end
            end
            BK_WRITE: begin
                rw_we    = 1'b1;
                org_we   = cmd_reg.wr_orig;
                acc_next = '0;
                if (cmd_reg.do_h) begin
                    d_next     = cmd_reg.dh_lo;
                    state_next = BK_HREAD;
                end else if (cmd_reg.do_out) begin
                    d_next     = cmd_reg.dv_lo;
                    state_next = BK_VREAD;
                end else begin
                    state_next = BK_IDLE;
                end
            end
            BK_HREAD: begin
                rdv_next = 1'b1;
                if (d_reg == cmd_reg.dh_hi) begin
                    state_next = BK_HLAST;
                end else begin
                    d_next = d_reg + 1'b1;
                end
            end
            BK_HLAST: begin
                hm_we    = 1'b1;
                acc_next = '0;
                if (cmd_reg.do_out) begin
                    d_next     = cmd_reg.dv_lo;
                    state_next = BK_VREAD;
                end else begin
                    state_next = BK_IDLE;
                end
            end
            BK_VREAD: begin
                rdv_next = 1'b1;
                if (d_reg == cmd_reg.dv_hi) begin
                    state_next = BK_VLAST;
                end else begin
                    d_next = d_reg + 1'b1;
                end
            end
            BK_VLAST: begin
                bg_next   = (hm_q > acc_reg) ? hm_q : acc_reg;
                rem_next  = '0;
                step_next = '0;
                if (bg_next == '0) begin
                    quo_next   = '0;
                    state_next = BK_OUT;
                end else begin
                    quo_next   = {8'd0, org_q} * 16'd255;
                    state_next = BK_DIV;
                end
            end
            BK_DIV: begin
                if (rem_sh >= {1'b0, bg_reg}) begin
                    rem_next = 8'(rem_sh - {1'b0, bg_reg});
                    quo_next = {quo_reg[14:0], 1'b1};
                end else begin
                    rem_next = rem_sh[7:0];
                    quo_next = {quo_reg[14:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == 4'd15) begin
                    state_next = BK_OUT;
                end
            end
            BK_OUT: begin
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    md_next    = (quo_reg[15:8] != '0) ? 8'd255 : quo_reg[7:0];
                    mu_next    = cmd_reg.row_end;
                    ml_next    = cmd_reg.frame_end;
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rw_we) begin
            rw_mem[cmd_reg.xr] <= cmd_reg.pix;
        end
        rw_q <= rw_mem[rw_raddr];
    end

    always_ff @(posedge aclk) begin
        if (org_we) begin
            orig_mem[org_waddr] <= cmd_reg.pix;
        end
        org_q <= orig_mem[org_raddr];
    end

    always_ff @(posedge aclk) begin
        if (hm_we) begin
            hmax_mem[hm_waddr] <= hm_wdata;
        end
        hm_q <= hmax_mem[hm_raddr];
    end

    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        d_reg    <= d_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        bg_reg   <= bg_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
        md_reg   <= md_next;
        mu_reg   <= mu_next;
        ml_reg   <= ml_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            rdv_reg   <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            rdv_reg   <= rdv_next;
            mv_reg    <= mv_next;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tuser  = mu_reg;
    assign m_tlast  = ml_reg;

endmodule

[rtl/core/background_normalize_max_filter.sv]
// ----------------------------------------------------------------------------
// background_normalize_max_filter
// Divides each gray pixel by a separable maximum-filter background estimate.
// ----------------------------------------------------------------------------
// The front takes one beat per cycle, while the queue is not full, into a
// four-entry command queue. The back finishes one command before it pops the
// next: it writes the line stores, takes the horizontal and then the vertical
// window maximum (radius r = 2*kernel_size) where the beat needs them, and for
// a result beat divides by that maximum (radix-2, skipped if 0) and sends it.
module background_normalize_max_filter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // pixel[7:0]
    input  logic        s_tuser,   // frame_first
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_pixel[7:0]
    output logic        m_tuser,   // row_end
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import bnmf_pkg::*;

    logic [XW-1:0] width_reg, width_next;
    logic [15:0]   height_reg, height_next;
    logic [3:0]    kernel_reg, kernel_next;
    cfg_t          cfg;
    cmd_t          f_cmd, q_cmd;
    logic          push, pop, full, empty;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        kernel_next = kernel_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_WIDTH:  width_next  = cfg_data[XW-1:0];
                REG_HEIGHT: height_next = cfg_data;
                REG_KERNEL: kernel_next = cfg_data[3:0];
                default: ;
            endcase
        end
        cfg.width  = (width_reg == '0) ? XW'(1) :
                     (width_reg > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : width_reg;
        cfg.height = (height_reg == '0) ? 16'd1 : height_reg;
        cfg.radius = (kernel_reg > 4'(MAX_KERNEL)) ? RAD_W'(2 * MAX_KERNEL) :
                     RAD_W'({kernel_reg, 1'b0});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= XW'(1024);
            height_reg <= 16'd1;
            kernel_reg <= 4'd1;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            kernel_reg <= kernel_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = !full;
    assign push      = s_tvalid && !full;

    bnmf_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .push        (push),
        .pixel       (s_tdata),
        .frame_first (s_tuser),
        .cmd         (f_cmd)
    );

    bnmf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (f_cmd),
        .pop       (pop),
        .pop_data  (q_cmd),
        .full      (full),
        .empty     (empty)
    );

    bnmf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (empty),
        .q_data   (q_cmd),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[rtl/core/bnmf_checker.sv]
// ----------------------------------------------------------------------------
// bnmf_checker
// Port-level checks of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module bnmf_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("Stalled result beat changed.");

    a_frame_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("Frame end without row end.");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("Result valid right after reset.");

endmodule

bind background_normalize_max_filter bnmf_checker u_bnmf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

[bench/bnmf_norm_checker.sv]
// ----------------------------------------------------------------------------
// Normalized pixel checker
// Watches the configuration, pixel and result channels of the background
// normalization block, predicts every normalized pixel from the accepted input
// beats and compares each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bnmf_norm_checker
    import bnmf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          mismatch_count,
    output int          pending_count,
    output int          checked_count
);

    typedef struct packed {
        logic [7:0] pix;
        logic       row_end;
        logic       frame_end;
    } norm_beat_t;

    norm_beat_t  expected_pixels[$];
    norm_beat_t  want;
    logic [7:0]  hmax_rows[RING][MAX_WIDTH];
    logic [7:0]  orig_rows[RING][MAX_WIDTH];
    logic [7:0]  row_win[RING];
    int unsigned col_pos;
    int unsigned row_pos;
    logic [10:0] width_reg;
    logic [15:0] height_reg;
    logic [3:0]  kernel_reg;

    initial begin
        mismatch_count = 0;
        pending_count  = 0;
        checked_count  = 0;
    end

    task automatic predict_normalized(input logic [7:0] pix, input logic first);
        int unsigned w, h, r, x, y, c, lo, hi, bg, q, i;
        logic [7:0]  m;
        norm_beat_t  e;
        w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
        h = (height_reg == 0) ? 1 : height_reg;
        r = 2 * ((kernel_reg > MAX_KERNEL) ? MAX_KERNEL : kernel_reg);
        if (first) begin
            col_pos = 0;
            row_pos = 0;
        end
        x = col_pos;
        y = row_pos;
        row_win[x % RING] = pix;
        if (y < h && x < w) begin
            orig_rows[y % RING][x] = pix;
        end
        if (y < h && x >= r && x - r < w) begin
            c  = x - r;
            lo = (c >= r) ? c - r : 0;
            hi = (c + r < w - 1) ? c + r : w - 1;
            m  = 8'd0;
            for (i = lo; i <= hi; i++) begin
                if (row_win[i % RING] > m) begin
                    m = row_win[i % RING];
                end
            end
            hmax_rows[y % RING][c] = m;
        end
        if (y >= r && x >= r && y - r < h && x - r < w) begin
            lo = (y - r >= r) ? y - 2 * r : 0;
            hi = (y < h - 1) ? y : h - 1;
            bg = 0;
            q  = 0;
            for (i = lo; i <= hi; i++) begin
                if (hmax_rows[i % RING][x - r] > bg) begin
                    bg = hmax_rows[i % RING][x - r];
                end
            end
            if (bg != 0) begin
                q = (orig_rows[(y - r) % RING][x - r] * 255) / bg;
                if (q > 255) begin
                    q = 255;
                end
            end
            e.pix       = q[7:0];
            e.row_end   = (x - r == w - 1);
            e.frame_end = (x - r == w - 1) && (y - r == h - 1);
            expected_pixels.push_back(e);
        end
        col_pos = x + 1;
        if (col_pos >= w + r) begin
            col_pos = 0;
            row_pos = y + 1;
            if (row_pos >= h + r) begin
                row_pos = 0;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  = 11'd1024;
            height_reg = 16'd1;
            kernel_reg = 4'd1;
            col_pos    = 0;
            row_pos    = 0;
            foreach (row_win[i]) begin
                row_win[i] = 8'd0;
            end
            expected_pixels.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_WIDTH: begin
                        width_reg = cfg_data[10:0];
                    end
                    REG_HEIGHT: begin
                        height_reg = cfg_data;
                    end
                    REG_KERNEL: begin
                        kernel_reg = cfg_data[3:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (s_tvalid && s_tready) begin
                predict_normalized(s_tdata, s_tuser);
            end
            if (m_tvalid && m_tready) begin
                checked_count++;
                if (expected_pixels.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result beat pix=%0d row_end=%0b frame_end=%0b",
                             $time, m_tdata, m_tuser, m_tlast);
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_tdata !== want.pix) begin
                        mismatch_count++;
                        $display("%0t: out_pixel expected %0d actual %0d",
                                 $time, want.pix, m_tdata);
                    end
                    if (m_tuser !== want.row_end) begin
                        mismatch_count++;
                        $display("%0t: row_end expected %0b actual %0b",
                                 $time, want.row_end, m_tuser);
                    end
                    if (m_tlast !== want.frame_end) begin
                        mismatch_count++;
                        $display("%0t: frame_end expected %0b actual %0b",
                                 $time, want.frame_end, m_tlast);
                    end
                end
            end
        end
        pending_count = expected_pixels.size();
    end

endmodule

[bench/tb_background_normalize_max_filter.sv]
// ----------------------------------------------------------------------------
// Background normalization testbench
// Streams whole, wrapped and cut-short frames over many width, height and
// kernel settings, with random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_background_normalize_max_filter;
    import bnmf_pkg::*;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_WIDTH;
    logic [15:0] cfg_data  = 16'd0;

    int mismatch_count;
    int pending_count;
    int checked_count;
    int beats_sent  = 0;
    int frames_sent = 0;
    int fw, fh, fr;
    bit steady      = 1'b0;
    bit hold_go     = 1'b0;
    bit hold_done   = 1'b0;

    background_normalize_max_filter u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bnmf_norm_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .checked_count  (checked_count)
    );

    initial begin
        forever begin
            #4 aclk = ~aclk;
        end
    end

    initial begin
        #50_000_000;
        $display("background_normalize_max_filter test failed");
        $finish;
    end

    // The output side idles at random, except for one long hold-off.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_go && !hold_done) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_done = 1'b1;
            end else begin
                m_tready <= steady || ($urandom_range(99) >= 34);
            end
        end
    end

    task automatic send_beat(input logic [7:0] pix, input logic first);
        if (!steady && $urandom_range(99) < 34) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= first;
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
        beats_sent++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge aclk);
        while (!cfg_ready) @(negedge aclk);
        @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_count != 0);
        repeat (300) @(posedge aclk);
    endtask

    task automatic set_config(input int w, input int h, input int k);
        wait_idle();
        write_reg(REG_WIDTH, 16'(w));
        write_reg(REG_HEIGHT, 16'(h));
        write_reg(REG_KERNEL, 16'(k));
        fw = (w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
        fh = (h == 0) ? 1 : h;
        fr = 2 * ((k > MAX_KERNEL) ? MAX_KERNEL : k);
    endtask

    // Pixel styles: 0 random, 1 black, 2 white, 3 mostly black, 4 near black.
    task automatic send_frame(input int style, input bit mark_first, input int cut_at);
        int n;
        logic [7:0] pix;
        n = (fw + fr) * (fh + fr);
        frames_sent++;
        for (int i = 0; i < n; i++) begin
            if (cut_at > 0 && i == cut_at) begin
                break;
            end
            case (style)
                1: pix = 8'd0;
                2: pix = 8'd255;
                3: pix = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'd0;
                4: pix = 8'($urandom_range(3));
                default: pix = 8'($urandom_range(255));
            endcase
            send_beat(pix, mark_first && i == 0);
        end
    endtask

    initial begin
        int rnd_start;
        int w, h, k, n;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_config(1024, 0, 0);
        set_config(2047, 0, 0);
        send_frame(0, 1'b1, 64);
        set_config(0, 5, 15);
        send_frame(0, 1'b1, 0);
        set_config(6, 4, 1);
        send_frame(1, 1'b1, 0);
        send_frame(2, 1'b1, 0);
        send_frame(3, 1'b0, 0);
        send_frame(4, 1'b0, 0);
        send_frame(0, 1'b1, 21);
        send_frame(0, 1'b1, 0);
        set_config(1, 65535, 0);
        send_frame(0, 1'b1, 30);

        rnd_start = beats_sent;
        while (beats_sent - rnd_start < 600) begin
            if ($urandom_range(4) == 0) begin
                set_config($urandom_range(1, 3), $urandom_range(1, 3), $urandom_range(3, 15));
            end else begin
                set_config($urandom_range(1, 12), $urandom_range(1, 6), $urandom_range(0, 2));
            end
            n = $urandom_range(1, 3);
            for (int f = 0; f < n; f++) begin
                steady  = (beats_sent - rnd_start > 300) && (beats_sent - rnd_start < 450);
                hold_go = hold_go || (beats_sent - rnd_start > 150);
                if ($urandom_range(9) == 0) begin
                    send_frame($urandom_range(4), 1'b1,
                               $urandom_range(1, (fw + fr) * (fh + fr)));
                    send_frame($urandom_range(4), 1'b1, 0);
                end else begin
                    send_frame(($urandom_range(3) == 0) ? $urandom_range(4) : 0,
                               (f == 0) || ($urandom_range(1) == 0), 0);
                end
            end
        end
        steady = 1'b0;

        wait_idle();
        $display("Sent %0d pixel beats in %0d frames and checked %0d normalized pixels.",
                 beats_sent, frames_sent, checked_count);
        if (mismatch_count == 0) begin
            $display("background_normalize_max_filter test passed");
        end else begin
            $display("background_normalize_max_filter test failed");
        end
        $finish;
    end

endmodule
